@@ sv/tll_pkg.sv @@
// tll_pkg: shared types, token codes, character codes and keyword table
// for the lexer. No dependencies.
`timescale 1ns / 1ps

package tll_pkg;

  localparam int TEXT_BYTES_DEF = 8;
  localparam int VALUE_BITS_DEF = 32;
  localparam int QUEUE_DEPTH    = 4;
  localparam int NUM_KEYWORDS   = 8;

  localparam logic [4:0] K_SEMI   = 5'd8;
  localparam logic [4:0] K_ASSIGN = 5'd9;
  localparam logic [4:0] K_LT     = 5'd10;
  localparam logic [4:0] K_EQ     = 5'd11;
  localparam logic [4:0] K_PLUS   = 5'd12;
  localparam logic [4:0] K_MINUS  = 5'd13;
  localparam logic [4:0] K_TIMES  = 5'd14;
  localparam logic [4:0] K_OVER   = 5'd15;
  localparam logic [4:0] K_LPAREN = 5'd16;
  localparam logic [4:0] K_RPAREN = 5'd17;
  localparam logic [4:0] K_NUMBER = 5'd18;
  localparam logic [4:0] K_IDENT  = 5'd19;
  localparam logic [4:0] K_ERROR  = 5'd20;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  localparam logic [15:0] ASSIGN_TEXT = {CH_EQ, CH_COLON};

  // keyword text, first byte in the low bits, index is the token kind
  localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
    64'h6669,          // if
    64'h6E656874,      // then
    64'h65736C65,      // else
    64'h646E65,        // end
    64'h746165706572,  // repeat
    64'h6C69746E75,    // until
    64'h64616572,      // read
    64'h6574697277     // write
  };
  localparam logic [7:0] KW_LEN [NUM_KEYWORDS] = '{
    8'd2, 8'd4, 8'd4, 8'd3, 8'd6, 8'd5, 8'd4, 8'd5
  };

  // one request handed from front to back, word payload travels beside it
  typedef struct packed {
    logic        colon_err;
    logic        is_assign;
    logic        word_v;
    logic        all_letters;
    logic        all_digits;
    logic        sym_v;
    logic [4:0]  sym_kind;
    logic [7:0]  sym_char;
    logic [7:0]  length;
    logic [15:0] line;
  } tll_ent_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] text;
    logic [7:0]  length;
    logic [31:0] value;
  } tll_tok_t;

  // returns {hit, keyword index}
  function automatic logic [3:0] kw_lookup(logic [63:0] text, logic [7:0] len);
    logic [3:0] res;
    res = 4'd0;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (KW_LEN[k] == len && KW_TEXT[k] == text) begin
        res = {1'b1, 3'(k)};
      end
    end
    return res;
  endfunction

endpackage

@@ sv/tll_queue.sv @@
// tll_queue: small register queue between the lexer front and back.
// No package dependencies.
`timescale 1ns / 1ps

module tll_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ sv/tll_front.sv @@
// tll_front: accepts source bytes, tracks comment, colon and word state,
// and hands token requests to the queue. Depends on tll_pkg.
`timescale 1ns / 1ps

module tll_front #(
  parameter int TEXT_BYTES = tll_pkg::TEXT_BYTES_DEF,
  parameter int VALUE_BITS = tll_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic                    q_full,
  input  logic                    req_type,
  input  logic [7:0]              char_code,
  input  logic [15:0]             line_number,
  output logic                    q_wr,
  output tll_pkg::tll_ent_t       ent,
  output logic [TEXT_BYTES*8-1:0] ent_text,
  output logic [VALUE_BITS-1:0]   ent_value
);

  import tll_pkg::*;

  localparam int TW = TEXT_BYTES * 8;

  logic                  comment_r, comment_nxt;
  logic                  colon_r, colon_nxt;
  logic [TW-1:0]         text_r, text_nxt;
  logic [7:0]            len_r, len_nxt;
  logic                  digits_r, digits_nxt;
  logic                  letters_r, letters_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic                  accept, flush, app;
  logic [VALUE_BITS+3:0] val_ext, val_mul;

  function automatic logic is_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic logic [4:0] sym_kind_of(logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      CH_SEMI:   k = K_SEMI;
      CH_LT:     k = K_LT;
      CH_EQ:     k = K_EQ;
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_TIMES;
      CH_SLASH:  k = K_OVER;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      default:   k = K_ERROR;
    endcase
    return k;
  endfunction

  assign accept    = push && !q_full;
  assign ent_text  = text_r;
  assign ent_value = value_r;

  // value * 10 + digit, four guard bits catch the overflow
  assign val_ext = {4'b0000, value_r};
  assign val_mul = (val_ext << 3) + (val_ext << 1) + (VALUE_BITS + 4)'(char_code - 8'd48);

  always_comb begin
    comment_nxt     = comment_r;
    colon_nxt       = colon_r;
    text_nxt        = text_r;
    len_nxt         = len_r;
    digits_nxt      = digits_r;
    letters_nxt     = letters_r;
    value_nxt       = value_r;
    flush           = 1'b0;
    app             = 1'b0;
    ent             = '0;
    ent.line        = line_number;
    ent.length      = len_r;
    ent.all_letters = letters_r;
    ent.all_digits  = digits_r;
    ent.sym_char    = char_code;
    ent.sym_kind    = sym_kind_of(char_code);
    if (accept) begin
      if (colon_r) begin
        colon_nxt = 1'b0;
        if (!req_type && char_code == CH_EQ) begin
          ent.is_assign = 1'b1;
        end else begin
          ent.colon_err = 1'b1;
        end
      end
      if (!ent.is_assign) begin
        if (req_type) begin
          flush = 1'b1;
        end else if (char_code == CH_LBRACE) begin
          comment_nxt = 1'b1;
        end else if (char_code == CH_RBRACE) begin
          comment_nxt = 1'b0;
        end else if (comment_r) begin
          // inside a comment
        end else if (is_space(char_code)) begin
          flush = 1'b1;
        end else if (is_punct(char_code)) begin
          flush = 1'b1;
          if (char_code == CH_COLON) begin
            colon_nxt = 1'b1;
          end else begin
            ent.sym_v = 1'b1;
          end
        end else begin
          app = 1'b1;
        end
      end
      if (flush && len_r != 8'd0) begin
        ent.word_v  = 1'b1;
        text_nxt    = '0;
        len_nxt     = 8'd0;
        digits_nxt  = 1'b1;
        letters_nxt = 1'b1;
        value_nxt   = '0;
      end
      if (app) begin
        for (int i = 0; i < TEXT_BYTES; i++) begin
          if (len_r == 8'(i)) begin
            text_nxt[i*8 +: 8] = char_code;
          end
        end
        if (len_r != 8'd255) begin
          len_nxt = len_r + 8'd1;
        end
        letters_nxt = letters_r && is_alpha(char_code);
        if (is_digit(char_code)) begin
          value_nxt = (val_mul[VALUE_BITS+3:VALUE_BITS] != 4'd0) ? '1
                                                                 : val_mul[VALUE_BITS-1:0];
        end else begin
          digits_nxt = 1'b0;
        end
      end
    end
    q_wr = accept && (ent.colon_err || ent.is_assign || ent.word_v || ent.sym_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comment_r <= 1'b0;
      colon_r   <= 1'b0;
      text_r    <= '0;
      len_r     <= 8'd0;
      digits_r  <= 1'b1;
      letters_r <= 1'b1;
      value_r   <= '0;
    end else begin
      comment_r <= comment_nxt;
      colon_r   <= colon_nxt;
      text_r    <= text_nxt;
      len_r     <= len_nxt;
      digits_r  <= digits_nxt;
      letters_r <= letters_nxt;
      value_r   <= value_nxt;
    end
  end

endmodule

@@ sv/tll_back.sv @@
// tll_back: classifies words, expands each queued request into one or two
// tokens and holds them in the output register. Depends on tll_pkg.
`timescale 1ns / 1ps

module tll_back #(
  parameter int TEXT_BYTES = tll_pkg::TEXT_BYTES_DEF,
  parameter int VALUE_BITS = tll_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  tll_pkg::tll_ent_t       ent,
  input  logic [TEXT_BYTES*8-1:0] ent_text,
  input  logic [VALUE_BITS-1:0]   ent_value,
  output logic                    q_rd,
  output logic                    empty,
  input  logic                    pop,
  output logic [4:0]              token_kind,
  output logic [63:0]             token_text,
  output logic [7:0]              token_length,
  output logic [31:0]             number_value,
  output logic [15:0]             token_line,
  output logic                    is_last
);

  import tll_pkg::*;

  logic        out_v_r, out_v_nxt;
  logic        phase_r, phase_nxt;
  logic [63:0] text_ext, value_ext;
  logic [3:0]  kw;
  tll_tok_t    word_tok, colon_tok, sym_tok, t0, t1, sel;
  logic [1:0]  n_tok;
  logic        last, load;

  assign text_ext  = 64'(ent_text);
  assign value_ext = 64'(ent_value);
  assign kw        = kw_lookup(text_ext, ent.length);

  always_comb begin
    word_tok.text   = text_ext;
    word_tok.length = ent.length;
    word_tok.value  = 32'd0;
    if (ent.all_letters && kw[3]) begin
      word_tok.kind = 5'(kw[2:0]);
    end else if (ent.all_digits) begin
      word_tok.kind  = K_NUMBER;
      word_tok.value = value_ext[31:0];
    end else if (ent.all_letters) begin
      word_tok.kind = K_IDENT;
    end else begin
      word_tok.kind = K_ERROR;
    end

    colon_tok = '{kind: K_ERROR, text: 64'(CH_COLON), length: 8'd1, value: 32'd0};
    sym_tok   = '{kind: ent.sym_kind, text: 64'(ent.sym_char), length: 8'd1, value: 32'd0};

    t1    = sym_tok;
    n_tok = 2'd1;
    if (ent.is_assign) begin
      t0 = '{kind: K_ASSIGN, text: 64'(ASSIGN_TEXT), length: 8'd2, value: 32'd0};
    end else if (ent.colon_err) begin
      t0 = colon_tok;
      if (ent.word_v) begin
        t1    = word_tok;
        n_tok = 2'd2;
      end else if (ent.sym_v) begin
        n_tok = 2'd2;
      end
    end else if (ent.word_v) begin
      t0 = word_tok;
      if (ent.sym_v) begin
        n_tok = 2'd2;
      end
    end else begin
      t0 = sym_tok;
    end

    sel       = phase_r ? t1 : t0;
    last      = phase_r || n_tok == 2'd1;
    load      = !q_empty && (!out_v_r || pop);
    q_rd      = load && last;
    phase_nxt = load ? !last : phase_r;
    out_v_nxt = load || (out_v_r && !pop);
  end

  assign empty = !out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_kind   <= sel.kind;
      token_text   <= sel.text;
      token_length <= sel.length;
      number_value <= sel.value;
      token_line   <= ent.line;
      is_last      <= last;
    end
  end

endmodule

@@ sv/tiny_language_lexer.sv @@
// tiny_language_lexer: top level of the lexer, front, request queue and back.
// Depends on tll_pkg, tll_front, tll_queue and tll_back.
//
// Input side is a queue write port: an item (a source byte or an end of
// line mark with its line number) is taken on a clock edge with push high
// and full low. Result side is a queue read port: while empty is low the
// oldest token sits on the out_ ports and is taken on an edge with pop high.
// An item causes zero, one or two tokens; is_last marks the final one.
// A token passes through the request queue and then the output register
// before it is visible on the out_ ports.
// Throughput: one item per cycle while full is low; an item with two tokens
// holds the back end for both, and the 4-entry request queue absorbs that burst.
// The token path is set by the single output register in the back end.
// Reset empties the queue and output register and clears all word state; empty
// rises right after the reset edge. If pop stays low, the token holds, the
// queue fills and full rises until the receiver takes results again.
`timescale 1ns / 1ps

module tiny_language_lexer #(
  parameter int TEXT_BYTES = tll_pkg::TEXT_BYTES_DEF,
  parameter int VALUE_BITS = tll_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_req_type,
  input  logic [7:0]  in_char_code,
  input  logic [15:0] in_line_number,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  out_token_kind,
  output logic [63:0] out_token_text,
  output logic [7:0]  out_token_length,
  output logic [31:0] out_number_value,
  output logic [15:0] out_token_line,
  output logic        out_is_last
);

  import tll_pkg::*;

  localparam int TW = TEXT_BYTES * 8;
  localparam int EW = $bits(tll_ent_t);
  localparam int QW = EW + TW + VALUE_BITS;

  tll_ent_t              f_ent, b_ent;
  logic [TW-1:0]         f_text, b_text;
  logic [VALUE_BITS-1:0] f_value, b_value;
  logic                  q_wr, q_rd, q_full, q_empty;
  logic [QW-1:0]         q_rd_data;

  assign full    = q_full;
  assign b_ent   = tll_ent_t'(q_rd_data[QW-1 -: EW]);
  assign b_text  = q_rd_data[TW+VALUE_BITS-1 -: TW];
  assign b_value = q_rd_data[VALUE_BITS-1:0];

  tll_front #(
    .TEXT_BYTES (TEXT_BYTES),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .q_full      (q_full),
    .req_type    (in_req_type),
    .char_code   (in_char_code),
    .line_number (in_line_number),
    .q_wr        (q_wr),
    .ent         (f_ent),
    .ent_text    (f_text),
    .ent_value   (f_value)
  );

  tll_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data ({f_ent, f_text, f_value}),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  tll_back #(
    .TEXT_BYTES (TEXT_BYTES),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .ent          (b_ent),
    .ent_text     (b_text),
    .ent_value    (b_value),
    .q_rd         (q_rd),
    .empty        (empty),
    .pop          (pop),
    .token_kind   (out_token_kind),
    .token_text   (out_token_text),
    .token_length (out_token_length),
    .number_value (out_number_value),
    .token_line   (out_token_line),
    .is_last      (out_is_last)
  );

endmodule

@@ sv/tll_chk.sv @@
// tll_chk: port-level checks for tiny_language_lexer, bound to the top.
// Depends on tll_pkg.
`timescale 1ns / 1ps

module tll_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [4:0]  out_token_kind,
  input logic [63:0] out_token_text,
  input logic [7:0]  out_token_length,
  input logic [31:0] out_number_value,
  input logic [15:0] out_token_line,
  input logic        out_is_last
);

  import tll_pkg::*;

  // nothing to read right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("results present after reset");

  // a stalled token holds its kind, text, length and line
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_token_kind) && $stable(out_token_text)
                       && $stable(out_token_length) && $stable(out_token_line))
    else $error("stalled token changed");

  // every token has text
  a_length: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_token_length != 8'd0)
    else $error("token with zero length");

  // value only on numbers
  a_value: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_token_kind != K_NUMBER |-> out_number_value == 32'd0)
    else $error("value on a token that is no number");

  // assignment is a whole item on its own
  a_assign: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_token_kind == K_ASSIGN |-> out_token_length == 8'd2 && out_is_last)
    else $error("malformed assignment token");

endmodule

bind tiny_language_lexer tll_chk u_tll_chk (.*);
